// ===== hw/rtl/sha256_pkg.sv =====
// Package for the SHA-256 message hasher: queue entry type, FSM states,
// round constants, initial hash vector and the round/schedule functions.
// No dependencies.
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] PadByte = 8'h80;

  // One 32-bit message word on its way from the front to the back
  typedef struct packed {
    logic [31:0] word;
    logic        final_blk;   // last word of the last block of a message
  } qword_t;

  typedef enum logic [1:0] {
    FrontAccept,
    FrontPadFirst,
    FrontPadRest
  } front_state_e;

  typedef enum logic [1:0] {
    BackLoad,
    BackRound,
    BackAdd,
    BackOut
  } back_state_e;

  localparam logic [7:0][31:0] InitVector = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== hw/rtl/sha256_if.sv =====
// Channel interfaces of the SHA-256 hasher: byte input and digest output.
// Depends on nothing.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hw/rtl/sha256_front.sv =====
// Front end: packs message bytes into 32-bit words, counts the length and
// generates the padding words. Depends on sha256_pkg.
module sha256_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 byte_present_i,
  input  logic                 end_of_message_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output sha256_pkg::qword_t   q_data_o
);

  sha256_pkg::front_state_e state_q, state_d;
  logic [23:0] acc_q, acc_d;        // bytes of the partial word
  logic [1:0]  pos_q, pos_d;        // bytes in the partial word
  logic [3:0]  widx_q, widx_d;      // word index within the block
  logic [60:0] count_q, count_d;    // message length in bytes
  logic        extra_q, extra_d;    // padding needs a second block
  logic [63:0] bit_len;
  logic        fire;

  assign bit_len    = {count_q, 3'b000};
  assign in_ready_o = (state_q == sha256_pkg::FrontAccept) && !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  // Next state, word packing and padding
  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    pos_d    = pos_q;
    widx_d   = widx_q;
    count_d  = count_q;
    extra_d  = extra_q;
    q_push_o = 1'b0;
    q_data_o = '{word: 32'h0, final_blk: 1'b0};
    unique case (state_q)
      sha256_pkg::FrontAccept: begin
        if (fire) begin
          if (byte_present_i) begin
            acc_d   = {acc_q[15:0], data_byte_i};
            pos_d   = pos_q + 2'd1;
            count_d = count_q + 61'd1;
            if (pos_q == 2'd3) begin
              q_push_o = 1'b1;
              q_data_o = '{word: {acc_q, data_byte_i}, final_blk: 1'b0};
              widx_d   = widx_q + 4'd1;
            end
          end
          if (end_of_message_i) begin
            state_d = sha256_pkg::FrontPadFirst;
          end
        end
      end
      sha256_pkg::FrontPadFirst: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          case (pos_q)
            2'd0: q_data_o.word = {sha256_pkg::PadByte, 24'h0};
            2'd1: q_data_o.word = {acc_q[7:0], sha256_pkg::PadByte, 16'h0};
            2'd2: q_data_o.word = {acc_q[15:0], sha256_pkg::PadByte, 8'h0};
            default: q_data_o.word = {acc_q, sha256_pkg::PadByte};
          endcase
          // pad in word 14: word 15 of this block is zero, length goes next block
          extra_d = (widx_q == 4'd14);
          widx_d  = widx_q + 4'd1;
          pos_d   = 2'd0;
          state_d = sha256_pkg::FrontPadRest;
        end
      end
      sha256_pkg::FrontPadRest: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          widx_d   = widx_q + 4'd1;
          if (!extra_q && widx_q == 4'd14) begin
            q_data_o.word = bit_len[63:32];
          end else if (!extra_q && widx_q == 4'd15) begin
            q_data_o = '{word: bit_len[31:0], final_blk: 1'b1};
            count_d  = '0;
            state_d  = sha256_pkg::FrontAccept;
          end else if (widx_q == 4'd15) begin
            extra_d = 1'b0;
          end
        end
      end
      default: state_d = sha256_pkg::FrontAccept;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::FrontAccept;
      pos_q   <= '0;
      widx_q  <= '0;
      count_q <= '0;
      extra_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      widx_q  <= widx_d;
      count_q <= count_d;
      extra_q <= extra_d;
    end
  end

  // Partial word payload
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// ===== hw/rtl/sha256_fifo.sv =====
// Short word queue between the front end and the compression back end.
// Depends on sha256_pkg.
module sha256_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sha256_pkg::qword_t push_data_i,
  input  logic               pop_i,
  output sha256_pkg::qword_t head_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = sha256_pkg::QueuePtrW;

  sha256_pkg::qword_t mem_q [sha256_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(sha256_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PtrW'(1);
      if (do_pop)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== hw/rtl/sha256_back.sv =====
// Back end: loads 16 words, runs 64 rounds one per cycle, updates the
// chaining value and presents the digest. Depends on sha256_pkg.
module sha256_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha256_pkg::qword_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        digest_word_o,
  output logic [1:0]         word_index_o,
  output logic               last_word_o
);

  sha256_pkg::back_state_e state_q, state_d;
  logic [15:0][31:0] w_q, w_d;      // schedule window
  logic [7:0][31:0]  v_q, v_d;      // working variables a..h
  logic [7:0][31:0]  h_q, h_d;      // chaining value
  logic [5:0]        cnt_q, cnt_d;  // load word / round counter
  logic [1:0]        idx_q, idx_d;
  logic              fin_q, fin_d;
  logic [31:0]       t1, t2, w_new;

  // One round and one schedule step
  always_comb begin
    t1 = v_q[7] + sha256_pkg::big_sigma1(v_q[4])
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + sha256_pkg::RoundK[cnt_q] + w_q[0];
    t2 = sha256_pkg::big_sigma0(v_q[0])
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = w_q[0] + sha256_pkg::small_sigma0(w_q[1]) + w_q[9]
          + sha256_pkg::small_sigma1(w_q[14]);
  end

  assign pop_o       = (state_q == sha256_pkg::BackLoad) && !empty_i;
  assign out_valid_o = (state_q == sha256_pkg::BackOut);
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 2'd3);

  // Digest word select
  always_comb begin
    case (idx_q)
      2'd0:    digest_word_o = {h_q[0], h_q[1]};
      2'd1:    digest_word_o = {h_q[2], h_q[3]};
      2'd2:    digest_word_o = {h_q[4], h_q[5]};
      default: digest_word_o = {h_q[6], h_q[7]};
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    v_d     = v_q;
    h_d     = h_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    fin_d   = fin_q;
    unique case (state_q)
      sha256_pkg::BackLoad: begin
        if (pop_o) begin
          w_d   = {head_i.word, w_q[15:1]};
          fin_d = head_i.final_blk;
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd15) begin
            cnt_d   = '0;
            v_d     = h_q;
            state_d = sha256_pkg::BackRound;
          end
        end
      end
      sha256_pkg::BackRound: begin
        w_d   = {w_new, w_q[15:1]};
        v_d   = {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = sha256_pkg::BackAdd;
        end
      end
      sha256_pkg::BackAdd: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        idx_d   = '0;
        state_d = fin_q ? sha256_pkg::BackOut : sha256_pkg::BackLoad;
      end
      sha256_pkg::BackOut: begin
        if (out_ready_i) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            h_d     = sha256_pkg::InitVector;
            state_d = sha256_pkg::BackLoad;
          end
        end
      end
      default: state_d = sha256_pkg::BackLoad;
    endcase
  end

  // Control and chaining registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::BackLoad;
      h_q     <= sha256_pkg::InitVector;
      cnt_q   <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
  end

endmodule

// ===== hw/rtl/sha256_message_hasher_top.sv =====
// Top level of the SHA-256 message hasher: front end, word queue, back end.
// Depends on sha256_pkg, sha256_if, sha256_front, sha256_fifo, sha256_back.
//
//  channel | dir | beat
//  in_i    | in  | data_byte, byte_present, end_of_message
//  out_o   | out | digest_word, word_index, last_word (4 beats per message)
//
// The front takes one beat per cycle while it is not padding and the queue has
// room; each block costs the back 16 loads, 64 rounds and 1 add. The queue
// holds only four words, so the front stalls during the rounds and then
// resumes as the back pops the next block.
// A closing beat adds up to 18 padding words that the front emits in turn.
// Reset is asynchronous, active low, and restores the initial hash vector.
// An unread digest stalls the back; the front fills the queue, then stalls.
module sha256_message_hasher_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);

  sha256_pkg::qword_t push_data, head;
  logic push, pop, full, empty;

  sha256_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .data_byte_i      (in_i.data_byte),
    .byte_present_i   (in_i.byte_present),
    .end_of_message_i (in_i.end_of_message),
    .q_full_i         (full),
    .q_push_o         (push),
    .q_data_o         (push_data)
  );

  sha256_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  sha256_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .digest_word_o (out_o.digest_word),
    .word_index_o  (out_o.word_index),
    .last_word_o   (out_o.last_word)
  );

  // The front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && full))
    else $error("push into full queue");

  // Digest words come out in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_word) |=>
      (out_o.valid && out_o.word_index == $past(out_o.word_index) + 2'd1))
    else $error("digest word order broken");

  // After the last digest word the output goes quiet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_word) |=> !out_o.valid)
    else $error("output valid after last word");

endmodule
